[rtl/tgb_pkg.sv]
`timescale 1ns / 1ps

package tgb_pkg;

    // Fraction bits of the Q format used on every port.
    localparam int FRAC_BITS = 16;

    localparam int IN_W   = 32;                       // input field width
    localparam int OUT_W  = 32;                       // result field width
    localparam int DIFF_W = IN_W + 1;                 // edge and texture deltas
    localparam int PROD_W = 2 * DIFF_W;               // one signed product
    localparam int ACC_W  = PROD_W + 1;               // difference of two products
    localparam int NUM_W  = ACC_W + FRAC_BITS;        // scaled dividend magnitude
    localparam int QUO_W  = OUT_W + 2;                // quotient bits kept, with overflow bits
    localparam int DSH_W  = ACC_W + QUO_W - 1;        // aligned divisor
    localparam int CNT_W  = $clog2(QUO_W);            // divide step counter

    localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

    // Which difference of products the datapath is working on.
    typedef enum logic [2:0] {
        NUM_DET,
        NUM_TAN_X,
        NUM_TAN_Y,
        NUM_TAN_Z,
        NUM_BIN_X,
        NUM_BIN_Y,
        NUM_BIN_Z
    } num_sel_t;

    typedef struct packed {
        logic     load_first;
        logic     load_second;
        logic     load_diff;
        logic     mul_first;
        logic     mul_second;
        logic     acc_sub;
        logic     det_load;
        logic     div_init;
        logic     div_step;
        logic     quo_store;
        logic     out_load;
        num_sel_t sel;
    } dp_cmd_t;

    typedef struct packed {
        logic acc_zero;
    } dp_status_t;

endpackage

[rtl/tgb_ctrl.sv]
`timescale 1ns / 1ps

module tgb_ctrl
    import tgb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       out_valid,
    input  logic       out_stall,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL1,
        S_MUL2,
        S_SUB,
        S_DET,
        S_DIVINIT,
        S_DIV,
        S_STORE,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_THIRD
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    num_sel_t          sel_reg, sel_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && out_stall;
        cmd            = '0;
        cmd.sel        = sel_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (phase_reg)
                        PH_SECOND:
                        begin
                            cmd.load_second = 1'b1;
                            phase_next      = PH_THIRD;
                        end
                        PH_THIRD:
                        begin
                            cmd.load_diff = 1'b1;
                            phase_next    = PH_FIRST;
                            sel_next      = NUM_DET;
                            state_next    = S_MUL1;
                        end
                        default:
                        begin
                            cmd.load_first = 1'b1;
                            phase_next     = PH_SECOND;
                        end
                    endcase
                end
            end
            S_MUL1:
            begin
                cmd.mul_first = 1'b1;
                state_next    = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul_second = 1'b1;
                state_next     = S_SUB;
            end
            S_SUB:
            begin
                cmd.acc_sub = 1'b1;
                state_next  = (sel_reg == NUM_DET) ? S_DET : S_DIVINIT;
            end
            S_DET:
            begin
                cmd.det_load = 1'b1;
                if (status.acc_zero)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    sel_next   = NUM_TAN_X;
                    state_next = S_MUL1;
                end
            end
            S_DIVINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == CNT_W'(QUO_W - 1))
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_STORE:
            begin
                cmd.quo_store = 1'b1;
                if (sel_reg == NUM_BIN_Z)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    sel_next   = num_sel_t'(sel_reg + 3'd1);
                    state_next = S_MUL1;
                end
            end
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            phase_reg     <= PH_FIRST;
            sel_reg       <= NUM_DET;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The divide step counter never runs past the last quotient bit.
    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> cnt_reg <= CNT_W'(QUO_W - 1))
        else $error("divide step counter out of range");

    // A new result never overwrites one that is still waiting to be taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten");

    // A quotient is stored only after the full number of divide steps.
    a_full_divide: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_STORE |->
            ($past(state_reg) == S_DIV && $past(cnt_reg) == CNT_W'(QUO_W - 1)))
        else $error("quotient stored early");

    // The third vertex of a triangle starts the determinant.
    a_third_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_diff |=> (state_reg == S_MUL1 && sel_reg == NUM_DET))
        else $error("third vertex did not start the computation");

endmodule

[rtl/tgb_dp.sv]
`timescale 1ns / 1ps

module tgb_dp
    import tgb_pkg::*;
(
    input  logic                    clk,
    input  dp_cmd_t                 cmd,
    output dp_status_t              status,
    input  logic signed [IN_W-1:0]  pos_x,
    input  logic signed [IN_W-1:0]  pos_y,
    input  logic signed [IN_W-1:0]  pos_z,
    input  logic signed [IN_W-1:0]  tex_u,
    input  logic signed [IN_W-1:0]  tex_v,
    output logic signed [OUT_W-1:0] tangent_x,
    output logic signed [OUT_W-1:0] tangent_y,
    output logic signed [OUT_W-1:0] tangent_z,
    output logic signed [OUT_W-1:0] binormal_x,
    output logic signed [OUT_W-1:0] binormal_y,
    output logic signed [OUT_W-1:0] binormal_z,
    output logic                    degenerate
);

    // Stored vertices of the current triangle.
    logic [2:0][IN_W-1:0] first_pos_reg, second_pos_reg;
    logic [1:0][IN_W-1:0] first_tex_reg, second_tex_reg;

    // Edges and texture deltas.
    logic signed [2:0][DIFF_W-1:0] e1_reg, e2_reg;
    logic signed [DIFF_W-1:0]      du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg, det_reg;

    logic              neg_reg;
    logic [NUM_W-1:0]  rem_reg;
    logic [DSH_W-1:0]  dsh_reg;
    logic [QUO_W-1:0]  quo_reg;

    logic [5:0][OUT_W-1:0] vec_reg;
    logic [5:0][OUT_W-1:0] out_vec_reg;
    logic                  out_degen_reg;

    logic [2:0][IN_W-1:0] in_pos;
    logic signed [DIFF_W-1:0] op_a, op_b, op_c, op_d;
    logic signed [DIFF_W-1:0] mul_x, mul_y;
    logic signed [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  acc_mag, det_mag;
    logic [DSH_W-1:0]  rem_ext, rem_diff;
    logic              rem_ge;
    logic [OUT_W-1:0]  limit, mag32, quo_res;
    logic              quo_over;

    function automatic logic signed [DIFF_W-1:0] diff33(input logic [IN_W-1:0] a,
                                                        input logic [IN_W-1:0] b);
        diff33 = $signed({a[IN_W-1], a}) - $signed({b[IN_W-1], b});
    endfunction

    assign in_pos = {pos_z, pos_y, pos_x};

    // Operands of the two products that make up each difference.
    always_comb
    begin
        case (cmd.sel)
            NUM_TAN_X, NUM_TAN_Y, NUM_TAN_Z:
            begin
                op_a = dv2_reg;
                op_c = dv1_reg;
                case (cmd.sel)
                    NUM_TAN_X: begin op_b = e1_reg[0]; op_d = e2_reg[0]; end
                    NUM_TAN_Y: begin op_b = e1_reg[1]; op_d = e2_reg[1]; end
                    default:   begin op_b = e1_reg[2]; op_d = e2_reg[2]; end
                endcase
            end
            NUM_BIN_X, NUM_BIN_Y, NUM_BIN_Z:
            begin
                op_a = du1_reg;
                op_c = du2_reg;
                case (cmd.sel)
                    NUM_BIN_X: begin op_b = e2_reg[0]; op_d = e1_reg[0]; end
                    NUM_BIN_Y: begin op_b = e2_reg[1]; op_d = e1_reg[1]; end
                    default:   begin op_b = e2_reg[2]; op_d = e1_reg[2]; end
                endcase
            end
            default:
            begin
                op_a = du1_reg;
                op_b = dv2_reg;
                op_c = du2_reg;
                op_d = dv1_reg;
            end
        endcase
    end

    // One multiplier serves both products: the first in one cycle, the second in the next.
    assign mul_x = cmd.mul_second ? op_c : op_a;
    assign mul_y = cmd.mul_second ? op_d : op_b;
    assign prod  = mul_x * mul_y;

    assign acc_mag = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : acc_reg;
    assign det_mag = det_reg[ACC_W-1] ? ACC_W'(-det_reg) : det_reg;

    assign status.acc_zero = (acc_reg == '0);

    // One restoring divide step against the divisor aligned to the current bit.
    assign rem_ext  = {{(DSH_W-NUM_W){1'b0}}, rem_reg};
    assign rem_ge   = (rem_ext >= dsh_reg);
    assign rem_diff = rem_ext - dsh_reg;

    // Saturation of the finished quotient, then the sign.
    assign limit    = neg_reg ? SAT_NEG : SAT_POS;
    assign quo_over = (|quo_reg[QUO_W-1:OUT_W]) || (quo_reg[OUT_W-1:0] > limit);
    assign mag32    = quo_over ? limit : quo_reg[OUT_W-1:0];
    assign quo_res  = neg_reg ? OUT_W'(-mag32) : mag32;

    always_ff @(posedge clk)
    begin
        if (cmd.load_first)
        begin
            first_pos_reg <= in_pos;
            first_tex_reg <= {tex_v, tex_u};
        end
        if (cmd.load_second)
        begin
            second_pos_reg <= in_pos;
            second_tex_reg <= {tex_v, tex_u};
        end
        if (cmd.load_diff)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= diff33(second_pos_reg[k], first_pos_reg[k]);
                e2_reg[k] <= diff33(in_pos[k], first_pos_reg[k]);
            end
            du1_reg <= diff33(second_tex_reg[0], first_tex_reg[0]);
            dv1_reg <= diff33(second_tex_reg[1], first_tex_reg[1]);
            du2_reg <= diff33(tex_u, first_tex_reg[0]);
            dv2_reg <= diff33(tex_v, first_tex_reg[1]);
        end

        if (cmd.mul_first)
        begin
            prod_reg <= prod;
        end
        if (cmd.mul_second)
        begin
            acc_reg  <= {prod_reg[PROD_W-1], prod_reg};
            prod_reg <= prod;
        end
        if (cmd.acc_sub)
        begin
            acc_reg <= acc_reg - {prod_reg[PROD_W-1], prod_reg};
        end
        if (cmd.det_load)
        begin
            det_reg <= acc_reg;
        end

        if (cmd.div_init)
        begin
            neg_reg <= acc_reg[ACC_W-1] ^ det_reg[ACC_W-1];
            rem_reg <= {acc_mag, {FRAC_BITS{1'b0}}};
            dsh_reg <= {det_mag, {(QUO_W-1){1'b0}}};
            quo_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem_ge)
            begin
                rem_reg <= rem_diff[NUM_W-1:0];
            end
            dsh_reg <= dsh_reg >> 1;
            quo_reg <= {quo_reg[QUO_W-2:0], rem_ge};
        end
        if (cmd.quo_store)
        begin
            case (cmd.sel)
                NUM_TAN_X: vec_reg[0] <= quo_res;
                NUM_TAN_Y: vec_reg[1] <= quo_res;
                NUM_TAN_Z: vec_reg[2] <= quo_res;
                NUM_BIN_X: vec_reg[3] <= quo_res;
                NUM_BIN_Y: vec_reg[4] <= quo_res;
                NUM_BIN_Z: vec_reg[5] <= quo_res;
                default:   vec_reg[0] <= vec_reg[0];
            endcase
        end

        if (cmd.out_load)
        begin
            out_degen_reg <= (det_reg == '0);
            out_vec_reg   <= (det_reg == '0) ? '0 : vec_reg;
        end
    end

    assign tangent_x  = out_vec_reg[0];
    assign tangent_y  = out_vec_reg[1];
    assign tangent_z  = out_vec_reg[2];
    assign binormal_x = out_vec_reg[3];
    assign binormal_y = out_vec_reg[4];
    assign binormal_z = out_vec_reg[5];
    assign degenerate = out_degen_reg;

endmodule

[rtl/triangle_tangent_binormal.sv]
// Triangle tangent and binormal: vertices arrive one beat at a time, each with a position
// (pos_x, pos_y, pos_z) and a texture coordinate (tex_u, tex_v) in signed Q16.16, and every
// third vertex closes a triangle and yields one result beat with the tangent and binormal in
// signed Q16.16, truncated toward zero and saturated to the 32-bit range. A triangle whose
// texture determinant is zero gives zero vectors with degenerate set. The first and second
// vertex of a triangle are each taken without stalling the input. The third vertex holds
// the input stalled while one shared 33 by 33 bit multiplier forms the determinant and
// the six numerators, and one restoring divider produces each of the six components at one
// quotient bit per cycle (34 steps per component). A degenerate triangle skips the
// numerators and the divides. The result sits in an output register, so the next
// triangle's vertices are taken while it waits; only the hand-over of a further result
// waits for out_stall to fall.
`timescale 1ns / 1ps

module triangle_tangent_binormal
    import tgb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  logic signed [IN_W-1:0]  pos_x,
    input  logic signed [IN_W-1:0]  pos_y,
    input  logic signed [IN_W-1:0]  pos_z,
    input  logic signed [IN_W-1:0]  tex_u,
    input  logic signed [IN_W-1:0]  tex_v,
    output logic                    out_valid,
    input  logic                    out_stall,
    output logic signed [OUT_W-1:0] tangent_x,
    output logic signed [OUT_W-1:0] tangent_y,
    output logic signed [OUT_W-1:0] tangent_z,
    output logic signed [OUT_W-1:0] binormal_x,
    output logic signed [OUT_W-1:0] binormal_y,
    output logic signed [OUT_W-1:0] binormal_z,
    output logic                    degenerate
);

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences vertex capture, the multiply and accumulate steps,
    // the divide steps and the hand-over to the output register.
    tgb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    // The datapath holds the stored vertices, the deltas, the multiplier, the
    // accumulator, the divider and the result registers.
    tgb_dp u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .status     (status),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .tex_u      (tex_u),
        .tex_v      (tex_v),
        .tangent_x  (tangent_x),
        .tangent_y  (tangent_y),
        .tangent_z  (tangent_z),
        .binormal_x (binormal_x),
        .binormal_y (binormal_y),
        .binormal_z (binormal_z),
        .degenerate (degenerate)
    );

endmodule
